// File: rtl/core/stl_pkg.sv
// Shared types, constants and helper functions for the script token lexer.
// Has no dependencies. The interfaces, the top level and the checker use it.
`default_nettype none

package stl_pkg;

    localparam int OFFSET_BITS   = 24;
    localparam int LEN_BITS      = OFFSET_BITS + 1;
    localparam int KEYWORD_BYTES = 6;
    localparam int KW_BITS       = 8 * KEYWORD_BYTES;
    localparam int ICOUNT_BITS   = $clog2(KEYWORD_BYTES + 2);
    localparam int FIELD_BITS    = 24;
    localparam int LINE_BITS     = 24;
    localparam int KIND_BITS     = 6;
    localparam int CHAR_BITS     = 8;
    localparam int MAX_RESULTS   = 3;
    localparam int SLOT_BITS     = $clog2(MAX_RESULTS);
    localparam int CAND_COUNT    = 4;
    localparam int KW_COUNT      = 13;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;

    typedef logic [KIND_BITS-1:0] kind_t;
    typedef logic [CHAR_BITS-1:0] char_t;

    localparam kind_t K_LPAREN     = 6'd0;
    localparam kind_t K_RPAREN     = 6'd1;
    localparam kind_t K_LBRACE     = 6'd2;
    localparam kind_t K_RBRACE     = 6'd3;
    localparam kind_t K_SEMICOLON  = 6'd4;
    localparam kind_t K_COMMA      = 6'd5;
    localparam kind_t K_DOT        = 6'd6;
    localparam kind_t K_MINUS      = 6'd7;
    localparam kind_t K_PLUS       = 6'd8;
    localparam kind_t K_SLASH      = 6'd9;
    localparam kind_t K_STAR       = 6'd10;
    localparam kind_t K_BANG       = 6'd11;
    localparam kind_t K_EQUAL      = 6'd13;
    localparam kind_t K_LESS       = 6'd15;
    localparam kind_t K_GREATER    = 6'd17;
    localparam kind_t K_IDENT      = 6'd19;
    localparam kind_t K_STRING     = 6'd20;
    localparam kind_t K_NUMBER     = 6'd21;
    localparam kind_t K_KW_FIRST   = 6'd22;
    localparam kind_t K_ERROR      = 6'd35;
    localparam kind_t K_END        = 6'd36;

    localparam logic ERR_UNEXPECTED   = 1'b0;
    localparam logic ERR_UNTERMINATED = 1'b1;

    localparam char_t CH_TAB        = 8'h09;
    localparam char_t CH_LF         = 8'h0A;
    localparam char_t CH_CR         = 8'h0D;
    localparam char_t CH_SPACE      = 8'h20;
    localparam char_t CH_BANG       = 8'h21;
    localparam char_t CH_QUOTE      = 8'h22;
    localparam char_t CH_LPAREN     = 8'h28;
    localparam char_t CH_RPAREN     = 8'h29;
    localparam char_t CH_STAR       = 8'h2A;
    localparam char_t CH_PLUS       = 8'h2B;
    localparam char_t CH_COMMA      = 8'h2C;
    localparam char_t CH_MINUS      = 8'h2D;
    localparam char_t CH_DOT        = 8'h2E;
    localparam char_t CH_SLASH      = 8'h2F;
    localparam char_t CH_SEMICOLON  = 8'h3B;
    localparam char_t CH_LESS       = 8'h3C;
    localparam char_t CH_EQUAL      = 8'h3D;
    localparam char_t CH_GREATER    = 8'h3E;
    localparam char_t CH_UNDERSCORE = 8'h5F;
    localparam char_t CH_LBRACE     = 8'h7B;
    localparam char_t CH_RBRACE     = 8'h7D;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_COMMENT,
        MODE_OP
    } mode_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_BANG,
        OP_EQUAL,
        OP_LESS,
        OP_GREATER,
        OP_SLASH
    } pend_t;

    typedef struct packed {
        kind_t                 kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic [LINE_BITS-1:0]  line;
        logic                  err;
        logic                  last;
    } result_t;

    // Keyword text with the first byte in the low byte lane, zero padded.
    localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        KW_BITS'(48'h0000_0064_6E61),   // and
        KW_BITS'(48'h0000_6573_6C65),   // else
        KW_BITS'(48'h0065_736C_6166),   // false
        KW_BITS'(48'h0000_0072_6F66),   // for
        KW_BITS'(48'h0000_006E_7566),   // fun
        KW_BITS'(48'h0000_0000_6669),   // if
        KW_BITS'(48'h0000_006C_696E),   // nil
        KW_BITS'(48'h0000_0000_726F),   // or
        KW_BITS'(48'h0074_6E69_7270),   // print
        KW_BITS'(48'h6E72_7574_6572),   // return
        KW_BITS'(48'h0000_6575_7274),   // true
        KW_BITS'(48'h0000_0072_6176),   // var
        KW_BITS'(48'h0065_6C69_6877)    // while
    };

    localparam int KW_LEN [KW_COUNT] = '{3, 4, 5, 3, 3, 2, 3, 2, 5, 6, 4, 3, 5};

    function automatic logic is_alpha(input char_t c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_digit(input char_t c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic kind_t single_kind(input pend_t op);
        kind_t k;
        unique case (op)
            OP_BANG:    k = K_BANG;
            OP_EQUAL:   k = K_EQUAL;
            OP_LESS:    k = K_LESS;
            OP_GREATER: k = K_GREATER;
            default:    k = K_SLASH;
        endcase
        return k;
    endfunction

    function automatic kind_t keyword_kind(input logic [KW_BITS-1:0]     prefix,
                                           input logic [ICOUNT_BITS-1:0] count);
        kind_t k;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (count == ICOUNT_BITS'(KW_LEN[i]) && prefix == KW_TEXT[i]) begin
                k = KIND_BITS'(int'(K_KW_FIRST) + i);
            end
        end
        return k;
    endfunction

    // Token length as a cursor difference, folded into the output field.
    function automatic logic [FIELD_BITS-1:0] span(input logic [LEN_BITS-1:0]    stop,
                                                   input logic [OFFSET_BITS-1:0] from);
        logic [LEN_BITS-1:0] diff;
        diff = stop - LEN_BITS'(from);
        return FIELD_BITS'(diff);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/stl_in_if.sv
// Source byte channel of the script token lexer: valid/ready plus payload.
// Depends on stl_pkg for the field widths.
`default_nettype none

interface stl_in_if;
    logic                   valid;
    logic                   ready;
    logic [stl_pkg::CHAR_BITS-1:0] ch;
    logic                   has_char;
    logic                   last;

    modport source (output valid, ch, has_char, last, input ready);
    modport sink   (input valid, ch, has_char, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/stl_out_if.sv
// Token channel of the script token lexer: valid/ready plus payload.
// Depends on stl_pkg for the field widths and the kind type.
`default_nettype none

interface stl_out_if;
    logic                            valid;
    logic                            ready;
    stl_pkg::kind_t                  token_kind;
    logic [stl_pkg::FIELD_BITS-1:0]  start_offset;
    logic [stl_pkg::FIELD_BITS-1:0]  length;
    logic [stl_pkg::LINE_BITS-1:0]   line_number;
    logic                            error_code;
    logic                            last_result;

    modport source (output valid, token_kind, start_offset, length, line_number,
                    error_code, last_result, input ready);
    modport sink   (input valid, token_kind, start_offset, length, line_number,
                    error_code, last_result, output ready);
endinterface

`default_nettype wire

// File: rtl/core/script_token_lexer.sv
// Top level of the streaming script token lexer.
// Depends on stl_pkg, stl_in_if and stl_out_if.
//
//   Channel  Modport       Payload                                      Role
//   chars    stl_in_if     ch, has_char, last                           source bytes in
//   tokens   stl_out_if    token_kind, start_offset, length,            tokens out
//                          line_number, error_code, last_result
//
// One byte is taken per cycle; the scan state updates at the same edge and the
// tokens it causes (zero to three) land in a three-entry result buffer.
// The buffer drains one token per cycle as the sink allows, so a byte with n > 1
// tokens holds off input until one is left; 0- and 1-token bytes keep full rate.
// A new byte is taken while the final buffered token is being handed off.
// Reset returns the scanner to the start of a new source and empties the buffer.
`default_nettype none

module script_token_lexer (
    input  logic       clk,
    input  logic       rst_n,
    stl_in_if.sink     chars,
    stl_out_if.source  tokens
);

    stl_pkg::mode_t                      mode_reg,   mode_mid,   mode_next;
    stl_pkg::pend_t                      pend_reg,   pend_mid,   pend_next;
    logic [stl_pkg::OFFSET_BITS-1:0]     start_reg,  start_mid,  start_next;
    logic [stl_pkg::OFFSET_BITS-1:0]     cursor_reg, cursor_mid, cursor_next;
    logic [stl_pkg::LINE_BITS-1:0]       line_reg,   line_mid,   line_next;
    logic [stl_pkg::KW_BITS-1:0]         prefix_reg, prefix_mid, prefix_next;
    logic [stl_pkg::ICOUNT_BITS-1:0]     icount_reg, icount_mid, icount_next;

    stl_pkg::result_t                    slot_reg [stl_pkg::MAX_RESULTS];
    stl_pkg::result_t                    slot_next [stl_pkg::MAX_RESULTS];
    logic [stl_pkg::SLOT_BITS-1:0]       head_reg;
    logic [stl_pkg::SLOT_BITS-1:0]       rem_reg;
    logic [stl_pkg::SLOT_BITS-1:0]       rem_next;

    stl_pkg::result_t                    cand [stl_pkg::CAND_COUNT];
    logic [stl_pkg::CAND_COUNT-1:0]      cand_v;
    logic [2:0]                          fill;

    stl_pkg::char_t                      b;
    logic                                alnum;
    logic                                restart;
    logic                                in_fire;
    logic                                out_fire;

    assign b        = chars.ch;
    assign alnum    = stl_pkg::is_alpha(b) || stl_pkg::is_digit(b);
    assign out_fire = tokens.valid && tokens.ready;
    assign in_fire  = chars.valid && chars.ready;

    // The buffer may be refilled when empty or when its last token leaves now.
    assign chars.ready = (rem_reg == '0) ||
                         (rem_reg == stl_pkg::SLOT_BITS'(1) && tokens.ready);

    // Next scan state: first the effect of the byte, then the end-of-source reset.
    always_comb
    begin
        mode_mid   = mode_reg;
        pend_mid   = pend_reg;
        start_mid  = start_reg;
        cursor_mid = cursor_reg;
        line_mid   = line_reg;
        prefix_mid = prefix_reg;
        icount_mid = icount_reg;
        restart    = 1'b0;

        if (chars.has_char)
        begin
            unique case (mode_reg)
                stl_pkg::MODE_IDLE:
                begin
                    restart = 1'b1;
                end
                stl_pkg::MODE_IDENT:
                begin
                    if (alnum)
                    begin
                        for (int i = 0; i < stl_pkg::KEYWORD_BYTES; i++)
                        begin
                            if (icount_reg == stl_pkg::ICOUNT_BITS'(i))
                            begin
                                prefix_mid[i*8 +: 8] = b;
                            end
                        end
                        if (icount_reg <= stl_pkg::ICOUNT_BITS'(stl_pkg::KEYWORD_BYTES))
                        begin
                            icount_mid = icount_reg + stl_pkg::ICOUNT_BITS'(1);
                        end
                    end
                    else
                    begin
                        restart = 1'b1;
                    end
                end
                stl_pkg::MODE_NUMBER:
                begin
                    restart = !stl_pkg::is_digit(b);
                end
                stl_pkg::MODE_STRING:
                begin
                    if (b == stl_pkg::CH_QUOTE)
                    begin
                        mode_mid = stl_pkg::MODE_IDLE;
                    end
                    else if (b == stl_pkg::CH_LF && line_reg != stl_pkg::LINE_MAX)
                    begin
                        line_mid = line_reg + stl_pkg::LINE_BITS'(1);
                    end
                end
                stl_pkg::MODE_COMMENT:
                begin
                    restart = (b == stl_pkg::CH_LF);
                end
                stl_pkg::MODE_OP:
                begin
                    pend_mid = stl_pkg::OP_NONE;
                    if (pend_reg == stl_pkg::OP_SLASH && b == stl_pkg::CH_SLASH)
                    begin
                        mode_mid = stl_pkg::MODE_COMMENT;
                    end
                    else if (pend_reg != stl_pkg::OP_SLASH && b == stl_pkg::CH_EQUAL)
                    begin
                        mode_mid = stl_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        restart = 1'b1;
                    end
                end
                default:
                begin
                    restart = 1'b1;
                end
            endcase

            // The byte that ends a token starts whatever follows it.
            if (restart)
            begin
                mode_mid = stl_pkg::MODE_IDLE;
                pend_mid = stl_pkg::OP_NONE;
                case (b) inside
                    stl_pkg::CH_LF:
                    begin
                        if (line_reg != stl_pkg::LINE_MAX)
                        begin
                            line_mid = line_reg + stl_pkg::LINE_BITS'(1);
                        end
                    end
                    stl_pkg::CH_BANG:
                    begin
                        mode_mid  = stl_pkg::MODE_OP;
                        pend_mid  = stl_pkg::OP_BANG;
                        start_mid = cursor_reg;
                    end
                    stl_pkg::CH_EQUAL:
                    begin
                        mode_mid  = stl_pkg::MODE_OP;
                        pend_mid  = stl_pkg::OP_EQUAL;
                        start_mid = cursor_reg;
                    end
                    stl_pkg::CH_LESS:
                    begin
                        mode_mid  = stl_pkg::MODE_OP;
                        pend_mid  = stl_pkg::OP_LESS;
                        start_mid = cursor_reg;
                    end
                    stl_pkg::CH_GREATER:
                    begin
                        mode_mid  = stl_pkg::MODE_OP;
                        pend_mid  = stl_pkg::OP_GREATER;
                        start_mid = cursor_reg;
                    end
                    stl_pkg::CH_SLASH:
                    begin
                        mode_mid  = stl_pkg::MODE_OP;
                        pend_mid  = stl_pkg::OP_SLASH;
                        start_mid = cursor_reg;
                    end
                    stl_pkg::CH_QUOTE:
                    begin
                        mode_mid  = stl_pkg::MODE_STRING;
                        start_mid = cursor_reg;
                    end
                    default:
                    begin
                        if (stl_pkg::is_alpha(b))
                        begin
                            mode_mid   = stl_pkg::MODE_IDENT;
                            start_mid  = cursor_reg;
                            prefix_mid = stl_pkg::KW_BITS'(b);
                            icount_mid = stl_pkg::ICOUNT_BITS'(1);
                        end
                        else if (stl_pkg::is_digit(b))
                        begin
                            mode_mid  = stl_pkg::MODE_NUMBER;
                            start_mid = cursor_reg;
                        end
                    end
                endcase
            end

            if (cursor_reg != stl_pkg::OFFSET_MAX)
            begin
                cursor_mid = cursor_reg + stl_pkg::OFFSET_BITS'(1);
            end
        end

        if (chars.last)
        begin
            mode_next   = stl_pkg::MODE_IDLE;
            pend_next   = stl_pkg::OP_NONE;
            start_next  = '0;
            cursor_next = '0;
            line_next   = stl_pkg::LINE_BITS'(1);
            prefix_next = '0;
            icount_next = '0;
        end
        else
        begin
            mode_next   = mode_mid;
            pend_next   = pend_mid;
            start_next  = start_mid;
            cursor_next = cursor_mid;
            line_next   = line_mid;
            prefix_next = prefix_mid;
            icount_next = icount_mid;
        end
    end

    // Tokens caused by the byte, in order: the token it closes, the token it
    // starts and completes, the token flushed at end of source, the end token.
    always_comb
    begin
        for (int i = 0; i < stl_pkg::CAND_COUNT; i++)
        begin
            cand[i] = '0;
        end
        cand_v = '0;

        cand[0].line  = line_reg;
        cand[0].start = stl_pkg::FIELD_BITS'(start_reg);
        if (chars.has_char)
        begin
            unique case (mode_reg)
                stl_pkg::MODE_IDENT:
                begin
                    cand_v[0]      = !alnum;
                    cand[0].kind   = stl_pkg::keyword_kind(prefix_reg, icount_reg);
                    cand[0].length = stl_pkg::span(stl_pkg::LEN_BITS'(cursor_reg), start_reg);
                end
                stl_pkg::MODE_NUMBER:
                begin
                    cand_v[0]      = !stl_pkg::is_digit(b);
                    cand[0].kind   = stl_pkg::K_NUMBER;
                    cand[0].length = stl_pkg::span(stl_pkg::LEN_BITS'(cursor_reg), start_reg);
                end
                stl_pkg::MODE_STRING:
                begin
                    cand_v[0]      = (b == stl_pkg::CH_QUOTE);
                    cand[0].kind   = stl_pkg::K_STRING;
                    cand[0].length = stl_pkg::span(stl_pkg::LEN_BITS'(cursor_reg) +
                                                   stl_pkg::LEN_BITS'(1), start_reg);
                end
                stl_pkg::MODE_OP:
                begin
                    if (pend_reg == stl_pkg::OP_SLASH)
                    begin
                        cand_v[0]      = (b != stl_pkg::CH_SLASH);
                        cand[0].kind   = stl_pkg::K_SLASH;
                        cand[0].length = stl_pkg::FIELD_BITS'(1);
                    end
                    else if (b == stl_pkg::CH_EQUAL)
                    begin
                        cand_v[0]      = 1'b1;
                        cand[0].kind   = stl_pkg::single_kind(pend_reg) +
                                         stl_pkg::KIND_BITS'(1);
                        cand[0].length = stl_pkg::FIELD_BITS'(2);
                    end
                    else
                    begin
                        cand_v[0]      = 1'b1;
                        cand[0].kind   = stl_pkg::single_kind(pend_reg);
                        cand[0].length = stl_pkg::FIELD_BITS'(1);
                    end
                end
                default:
                begin
                    cand_v[0] = 1'b0;
                end
            endcase
        end

        cand[1].line   = line_reg;
        cand[1].start  = stl_pkg::FIELD_BITS'(cursor_reg);
        cand[1].length = stl_pkg::FIELD_BITS'(1);
        cand[1].err    = stl_pkg::ERR_UNEXPECTED;
        if (restart)
        begin
            cand_v[1] = 1'b1;
            case (b) inside
                stl_pkg::CH_LPAREN:    cand[1].kind = stl_pkg::K_LPAREN;
                stl_pkg::CH_RPAREN:    cand[1].kind = stl_pkg::K_RPAREN;
                stl_pkg::CH_LBRACE:    cand[1].kind = stl_pkg::K_LBRACE;
                stl_pkg::CH_RBRACE:    cand[1].kind = stl_pkg::K_RBRACE;
                stl_pkg::CH_SEMICOLON: cand[1].kind = stl_pkg::K_SEMICOLON;
                stl_pkg::CH_COMMA:     cand[1].kind = stl_pkg::K_COMMA;
                stl_pkg::CH_DOT:       cand[1].kind = stl_pkg::K_DOT;
                stl_pkg::CH_MINUS:     cand[1].kind = stl_pkg::K_MINUS;
                stl_pkg::CH_PLUS:      cand[1].kind = stl_pkg::K_PLUS;
                stl_pkg::CH_STAR:      cand[1].kind = stl_pkg::K_STAR;
                stl_pkg::CH_SPACE, stl_pkg::CH_CR, stl_pkg::CH_TAB, stl_pkg::CH_LF,
                stl_pkg::CH_BANG, stl_pkg::CH_EQUAL, stl_pkg::CH_LESS,
                stl_pkg::CH_GREATER, stl_pkg::CH_SLASH, stl_pkg::CH_QUOTE:
                begin
                    cand_v[1] = 1'b0;
                end
                default:
                begin
                    cand_v[1]    = !alnum;
                    cand[1].kind = stl_pkg::K_ERROR;
                end
            endcase
        end

        cand[2].line  = line_mid;
        cand[2].start = stl_pkg::FIELD_BITS'(start_mid);
        if (chars.last)
        begin
            unique case (mode_mid)
                stl_pkg::MODE_IDENT:
                begin
                    cand_v[2]      = 1'b1;
                    cand[2].kind   = stl_pkg::keyword_kind(prefix_mid, icount_mid);
                    cand[2].length = stl_pkg::span(stl_pkg::LEN_BITS'(cursor_mid), start_mid);
                end
                stl_pkg::MODE_NUMBER:
                begin
                    cand_v[2]      = 1'b1;
                    cand[2].kind   = stl_pkg::K_NUMBER;
                    cand[2].length = stl_pkg::span(stl_pkg::LEN_BITS'(cursor_mid), start_mid);
                end
                stl_pkg::MODE_STRING:
                begin
                    cand_v[2]      = 1'b1;
                    cand[2].kind   = stl_pkg::K_ERROR;
                    cand[2].err    = stl_pkg::ERR_UNTERMINATED;
                    cand[2].length = stl_pkg::span(stl_pkg::LEN_BITS'(cursor_mid), start_mid);
                end
                stl_pkg::MODE_OP:
                begin
                    cand_v[2]      = 1'b1;
                    cand[2].kind   = stl_pkg::single_kind(pend_mid);
                    cand[2].length = stl_pkg::FIELD_BITS'(1);
                end
                default:
                begin
                    cand_v[2] = 1'b0;
                end
            endcase
        end

        cand_v[3]      = chars.last;
        cand[3].kind   = stl_pkg::K_END;
        cand[3].start  = stl_pkg::FIELD_BITS'(cursor_mid);
        cand[3].length = '0;
        cand[3].line   = line_mid;

        // Pack the present tokens into the buffer, oldest first.
        for (int i = 0; i < stl_pkg::MAX_RESULTS; i++)
        begin
            slot_next[i] = '0;
        end
        fill = '0;
        for (int i = 0; i < stl_pkg::CAND_COUNT; i++)
        begin
            if (cand_v[i] && fill < 3'(stl_pkg::MAX_RESULTS))
            begin
                slot_next[fill[stl_pkg::SLOT_BITS-1:0]] = cand[i];
                fill = fill + 3'd1;
            end
        end
        rem_next = fill[stl_pkg::SLOT_BITS-1:0];
        if (fill != '0)
        begin
            slot_next[rem_next - stl_pkg::SLOT_BITS'(1)].last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= stl_pkg::MODE_IDLE;
            pend_reg   <= stl_pkg::OP_NONE;
            start_reg  <= '0;
            cursor_reg <= '0;
            line_reg   <= stl_pkg::LINE_BITS'(1);
            prefix_reg <= '0;
            icount_reg <= '0;
        end
        else if (in_fire)
        begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            start_reg  <= start_next;
            cursor_reg <= cursor_next;
            line_reg   <= line_next;
            prefix_reg <= prefix_next;
            icount_reg <= icount_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            rem_reg  <= '0;
        end
        else if (in_fire)
        begin
            head_reg <= '0;
            rem_reg  <= rem_next;
        end
        else if (out_fire)
        begin
            head_reg <= head_reg + stl_pkg::SLOT_BITS'(1);
            rem_reg  <= rem_reg - stl_pkg::SLOT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            slot_reg <= slot_next;
        end
    end

    assign tokens.valid        = (rem_reg != '0);
    assign tokens.token_kind   = slot_reg[head_reg].kind;
    assign tokens.start_offset = slot_reg[head_reg].start;
    assign tokens.length       = slot_reg[head_reg].length;
    assign tokens.line_number  = slot_reg[head_reg].line;
    assign tokens.error_code   = slot_reg[head_reg].err;
    assign tokens.last_result  = slot_reg[head_reg].last;

endmodule

`default_nettype wire

// File: rtl/core/stl_checker.sv
// Port-level checks on the token channel of the script token lexer.
// Depends on stl_pkg; bound to script_token_lexer at the end of this file.
`default_nettype none

module stl_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input stl_pkg::kind_t                  kind,
    input logic [stl_pkg::FIELD_BITS-1:0]  start,
    input logic [stl_pkg::FIELD_BITS-1:0]  length,
    input logic [stl_pkg::LINE_BITS-1:0]   line,
    input logic                            err,
    input logic                            last_res
);

    // A stalled transaction keeps its token unchanged.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(start) &&
                                    $stable(length) && $stable(line) &&
                                    $stable(err) && $stable(last_res))
        else $error("token changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= stl_pkg::K_END)
        else $error("token kind out of range");

    a_err_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && err |-> kind == stl_pkg::K_ERROR)
        else $error("error code set on a non-error token");

    // The end token is empty and always closes the transaction group of its byte.
    a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == stl_pkg::K_END |-> length == '0 && last_res)
        else $error("malformed end token");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> line != '0)
        else $error("line number is zero");

endmodule

bind script_token_lexer stl_checker u_stl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (tokens.valid),
    .out_ready (tokens.ready),
    .kind      (tokens.token_kind),
    .start     (tokens.start_offset),
    .length    (tokens.length),
    .line      (tokens.line_number),
    .err       (tokens.error_code),
    .last_res  (tokens.last_result)
);

`default_nettype wire
